// ===== rtl/grid_best_first_path_search_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the grid path search block
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef GRID_BEST_FIRST_PATH_SEARCH_TOP_ASSERT_SVH
`define GRID_BEST_FIRST_PATH_SEARCH_TOP_ASSERT_SVH

// same-cycle implication
`define GBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gbfps_pkg.sv =====
// ----------------------------------------------------------------------------
// gbfps_pkg
// Sizes and codes of the grid path search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gbfps_pkg;
  localparam int unsigned MAX_WIDTH  = 8;
  localparam int unsigned MAX_HEIGHT = 8;
  localparam int unsigned XW = 3;
  localparam int unsigned YW = 3;
  localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW = XW + YW;
  localparam int unsigned CW = AW + 1;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic [1:0] ST_MOVE    = 2'd0;
  localparam logic [1:0] ST_AT_GOAL = 2'd1;
  localparam logic [1:0] ST_NO_PATH = 2'd2;

  localparam logic [2:0] REG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_START_X = 3'd2;
  localparam logic [2:0] REG_START_Y = 3'd3;
  localparam logic [2:0] REG_GOAL_X  = 3'd4;
  localparam logic [2:0] REG_GOAL_Y  = 3'd5;
endpackage

// ===== rtl/grid_best_first_path_search_top.sv =====
// ----------------------------------------------------------------------------
// grid_best_first_path_search_top
// Loads a door grid and searches a greedy best-first path to the goal.
// ----------------------------------------------------------------------------
// Cells load one beat per cycle. The beat flagged last_cell starts a search
// run by one small sequencer around a single distance/compare unit: each
// expansion scans the open list entry by entry, a read and then an evaluate
// step for each, removes the chosen entry by a shift sweep of a read and a
// write step per moved entry, and tries the four neighbours in turn. The path
// is then traced back and sent out move by move. While a run is busy the
// input is stalled.
`timescale 1ns / 1ps
module grid_best_first_path_search_top import gbfps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] door_mask_i,
  input  logic       last_cell_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] move_direction_o,
  output logic [1:0] status_o,
  output logic       last_move_o
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SC_RD = 4'd2;
  localparam logic [3:0] S_SC_EV = 4'd3;
  localparam logic [3:0] S_DOOR  = 4'd4;
  localparam logic [3:0] S_SH_RD = 4'd5;
  localparam logic [3:0] S_SH_WR = 4'd6;
  localparam logic [3:0] S_NEIGH = 4'd7;
  localparam logic [3:0] S_TR_RD = 4'd8;
  localparam logic [3:0] S_TR_EV = 4'd9;
  localparam logic [3:0] S_PO_RD = 4'd10;
  localparam logic [3:0] S_PO_EV = 4'd11;
  localparam logic [3:0] S_STAT  = 4'd12;

  logic [3:0] state_q, state_d;
  logic [3:0] w_q, h_q;
  logic [XW-1:0] sx_q, gx_q;
  logic [YW-1:0] sy_q, gy_q;
  logic [CW-1:0] load_q, load_d, cnt_q, cnt_d, n_q, n_d;
  logic [AW-1:0] i_q, i_d, best_q, best_d, d_q, d_d, r_q, r_d;
  logic [AW-1:0] bxy_q, bxy_d;
  logic [3:0] bestd_q, bestd_d;
  logic [1:0] nb_q, nb_d, stat_q, stat_d;
  logic [XW-1:0] cx_q, cx_d;
  logic [YW-1:0] cy_q, cy_d;
  logic [CELLS-1:0] seen_q, seen_d;
  logic       ov_q, ov_d, olast_q, olast_d;
  logic [1:0] odir_q, odir_d, ost_q, ost_d;

  logic [3:0] door_mem [CELLS];
  logic [1:0] par_mem  [CELLS];
  logic [AW-1:0] q_mem [CELLS];
  logic [1:0] path_mem [CELLS];
  logic [3:0] door_rd_q;
  logic       loaded_q;
  logic [1:0] par_rd_q, path_rd_q;
  logic [AW-1:0] q_rd_q;

  logic          door_we, door_re, par_we, q_we, path_we;
  logic [AW-1:0] door_wa, par_wa, q_wa, q_ra, par_ra, path_wa, path_ra;
  logic [1:0]    par_wd, path_wd;
  logic [AW-1:0] q_wd;

  logic [3:0] w_eff, h_eff;
  logic [CW-1:0] cells;
  logic [CW-1:0] blin;
  logic [XW-1:0] qx, nx;
  logic [YW-1:0] qy, ny;
  logic [3:0] qd;
  logic       take, nb_ok, out_ok;
  logic [1:0] nb_code;
  logic [3:0] door_eff;

  assign w_eff = (w_q == 4'd0) ? 4'd1 : ((w_q > 4'(MAX_WIDTH)) ? 4'(MAX_WIDTH) : w_q);
  assign h_eff = (h_q == 4'd0) ? 4'd1 : ((h_q > 4'(MAX_HEIGHT)) ? 4'(MAX_HEIGHT) : h_q);
  assign cells = CW'(w_eff * h_eff);
  assign blin  = CW'(bxy_q[AW-1:XW] * w_eff) + CW'(bxy_q[XW-1:0]);
  assign qx = q_rd_q[XW-1:0];
  assign qy = q_rd_q[AW-1:XW];
  assign qd = 4'((qx > gx_q) ? qx - gx_q : gx_q - qx) +
              4'((qy > gy_q) ? qy - gy_q : gy_q - qy);
  assign take = (i_q == '0) || (qd < bestd_q);
  assign out_ok = !ov_q || !out_stall_i;
  assign door_eff = loaded_q ? door_rd_q : 4'd0;

  always_comb begin
    nx = bxy_q[XW-1:0];
    ny = bxy_q[AW-1:XW];
    nb_ok = 1'b0;
    nb_code = DIR_UP;
    unique case (nb_q)
      2'd0: begin
        ny = ny - 1'b1;
        nb_ok = door_eff[1] && (bxy_q[AW-1:XW] != '0);
        nb_code = DIR_UP;
      end
      2'd1: begin
        ny = ny + 1'b1;
        nb_ok = door_eff[3] && ((4'(bxy_q[AW-1:XW]) + 4'd1) < h_eff);
        nb_code = DIR_DOWN;
      end
      2'd2: begin
        nx = nx - 1'b1;
        nb_ok = door_eff[2] && (bxy_q[XW-1:0] != '0);
        nb_code = DIR_LEFT;
      end
      default: begin
        nx = nx + 1'b1;
        nb_ok = door_eff[0] && ((4'(bxy_q[XW-1:0]) + 4'd1) < w_eff);
        nb_code = DIR_RIGHT;
      end
    endcase
  end

  always_comb begin
    state_d = state_q; load_d = load_q; cnt_d = cnt_q; n_d = n_q;
    i_d = i_q; best_d = best_q; d_d = d_q; r_d = r_q; bxy_d = bxy_q;
    bestd_d = bestd_q; nb_d = nb_q; stat_d = stat_q; cx_d = cx_q; cy_d = cy_q;
    seen_d = seen_q;
    ov_d = ov_q && out_stall_i; odir_d = odir_q; ost_d = ost_q; olast_d = olast_q;
    door_we = 1'b0; door_wa = load_q[AW-1:0]; door_re = 1'b0;
    par_we = 1'b0; par_wa = {ny, nx}; par_wd = nb_code; par_ra = {cy_q, cx_q};
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = i_q;
    path_we = 1'b0; path_wa = n_q[AW-1:0]; path_wd = par_rd_q;
    path_ra = AW'(n_q - CW'(r_q) - CW'(1));
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (load_q < cells) begin
            door_we = 1'b1;
            load_d = load_q + 1'b1;
          end
          if (last_cell_i) state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((4'(sx_q) >= w_eff) || (4'(sy_q) >= h_eff)) begin
          stat_d = ST_NO_PATH; state_d = S_STAT;
        end else if ((sx_q == gx_q) && (sy_q == gy_q)) begin
          stat_d = ST_AT_GOAL; state_d = S_STAT;
        end else begin
          seen_d = '0;
          seen_d[{sy_q, sx_q}] = 1'b1;
          q_we = 1'b1; q_wa = '0; q_wd = {sy_q, sx_q};
          cnt_d = CW'(1); i_d = '0; state_d = S_SC_RD;
        end
      end
      S_SC_RD: state_d = S_SC_EV;
      S_SC_EV: begin
        if (take) begin
          best_d = i_q; bestd_d = qd; bxy_d = q_rd_q;
        end
        if (CW'(i_q) + CW'(1) == cnt_q) begin
          if (bestd_d == 4'd0) begin
            cx_d = bxy_d[XW-1:0]; cy_d = bxy_d[AW-1:XW];
            n_d = '0; state_d = S_TR_RD;
          end else begin
            state_d = S_DOOR;
          end
        end else begin
          i_d = i_q + 1'b1; state_d = S_SC_RD;
        end
      end
      S_DOOR: begin
        door_re = 1'b1; d_d = best_q; state_d = S_SH_RD;
      end
      S_SH_RD: begin
        q_ra = d_q + 1'b1;
        if (CW'(d_q) + CW'(1) < cnt_q) begin
          state_d = S_SH_WR;
        end else begin
          cnt_d = cnt_q - 1'b1; nb_d = 2'd0; state_d = S_NEIGH;
        end
      end
      S_SH_WR: begin
        q_we = 1'b1; q_wa = d_q; q_wd = q_rd_q;
        d_d = d_q + 1'b1; state_d = S_SH_RD;
      end
      S_NEIGH: begin
        if (nb_ok && !seen_q[{ny, nx}]) begin
          seen_d[{ny, nx}] = 1'b1;
          par_we = 1'b1;
          q_we = 1'b1; q_wa = cnt_q[AW-1:0]; q_wd = {ny, nx};
          cnt_d = cnt_q + 1'b1;
        end
        nb_d = nb_q + 1'b1;
        if (nb_q == 2'd3) begin
          i_d = '0;
          if (cnt_d == '0) begin
            stat_d = ST_NO_PATH; state_d = S_STAT;
          end else begin
            state_d = S_SC_RD;
          end
        end
      end
      S_TR_RD: begin
        if (((cy_q == sy_q) && (cx_q == sx_q)) || (n_q >= cells)) begin
          r_d = '0; state_d = S_PO_RD;
        end else begin
          state_d = S_TR_EV;
        end
      end
      S_TR_EV: begin
        path_we = 1'b1;
        n_d = n_q + 1'b1;
        unique case (par_rd_q)
          DIR_LEFT:  cx_d = cx_q + 1'b1;
          DIR_RIGHT: cx_d = cx_q - 1'b1;
          DIR_UP:    cy_d = cy_q + 1'b1;
          default:   cy_d = cy_q - 1'b1;
        endcase
        state_d = S_TR_RD;
      end
      S_PO_RD: state_d = S_PO_EV;
      S_PO_EV: begin
        if (out_ok) begin
          ov_d = 1'b1; odir_d = path_rd_q; ost_d = ST_MOVE;
          olast_d = (CW'(r_q) + CW'(1) == n_q);
          if (olast_d) begin
            load_d = '0; state_d = S_IDLE;
          end else begin
            r_d = r_q + 1'b1; state_d = S_PO_RD;
          end
        end
      end
      S_STAT: begin
        if (out_ok) begin
          ov_d = 1'b1; odir_d = DIR_LEFT; ost_d = stat_q; olast_d = 1'b1;
          load_d = '0; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      w_q <= 4'd1; h_q <= 4'd1;
      sx_q <= '0; sy_q <= '0; gx_q <= '0; gy_q <= '0;
      load_q <= '0; cnt_q <= '0; seen_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      load_q <= load_d; cnt_q <= cnt_d; seen_q <= seen_d; ov_q <= ov_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WIDTH:   w_q <= cfg_data_i;
          REG_HEIGHT:  h_q <= cfg_data_i;
          REG_START_X: sx_q <= cfg_data_i[XW-1:0];
          REG_START_Y: sy_q <= cfg_data_i[YW-1:0];
          REG_GOAL_X:  gx_q <= cfg_data_i[XW-1:0];
          REG_GOAL_Y:  gy_q <= cfg_data_i[YW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; i_q <= i_d; best_q <= best_d; d_q <= d_d; r_q <= r_d;
    bxy_q <= bxy_d; bestd_q <= bestd_d; nb_q <= nb_d; stat_q <= stat_d;
    cx_q <= cx_d; cy_q <= cy_d;
    odir_q <= odir_d; ost_q <= ost_d; olast_q <= olast_d;
  end

  always_ff @(posedge clk_i) begin
    if (door_we) door_mem[door_wa] <= door_mask_i;
    if (door_re) begin
      door_rd_q <= door_mem[blin[AW-1:0]];
      loaded_q  <= blin < load_q;
    end
    if (par_we) par_mem[par_wa] <= par_wd;
    par_rd_q <= par_mem[par_ra];
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd_q <= q_mem[q_ra];
    if (path_we) path_mem[path_wa] <= path_wd;
    path_rd_q <= path_mem[path_ra];
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = ov_q;
  assign move_direction_o = odir_q;
  assign status_o         = ost_q;
  assign last_move_o      = olast_q;
endmodule

// ===== rtl/gbfps_checker.sv =====
// ----------------------------------------------------------------------------
// gbfps_checker
// Port-level checks of the grid path search block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_best_first_path_search_top_assert.svh"
module gbfps_checker import gbfps_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] move_direction_o,
  input logic [1:0] status_o,
  input logic       last_move_o
);
  `GBF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(move_direction_o) && $stable(status_o) && $stable(last_move_o), "stalled output beat changed")
  `GBF_ASSERT_NOW(a_status_last, out_valid_o && (status_o != ST_MOVE), last_move_o, "status beat not marked last")
  `GBF_ASSERT_NOW(a_status_code, out_valid_o, status_o == ST_MOVE || status_o == ST_AT_GOAL || status_o == ST_NO_PATH, "bad status code")
  `GBF_ASSERT_NOW(a_status_dir, out_valid_o && (status_o != ST_MOVE), move_direction_o == DIR_LEFT, "status beat carries a move")
endmodule

bind grid_best_first_path_search_top gbfps_checker u_gbfps_checker (.*);
